@@ hdl/htw_pkg.sv @@
`timescale 1ns / 1ps
// Package for the hierarchical timing wheel unit.
// Default sizes, command codes and sequencer state types. No dependencies.
package htw_pkg;

  localparam int TIMER_COUNT_DEF = 64;
  localparam int NEAR_BITS_DEF   = 8;
  localparam int LEVEL_BITS_DEF  = 6;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_ARM  = 2'd1;
  localparam logic [1:0] FUNC_KILL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_ADD,
    ST_SUB,
    ST_FILE,
    ST_INC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MODE_ARM,
    MODE_CASC,
    MODE_EXP
  } mode_e;

endpackage

@@ hdl/hierarchical_timing_wheel_unit.sv @@
`timescale 1ns / 1ps
// Hierarchical timing wheel: arm, kill and millisecond tick over one shared 64-bit adder.
// Depends on htw_pkg.
// Arm runs through ST_ADD, ST_SUB and ST_FILE; kill and unused codes finish on acceptance. A tick
// runs up to 4 cascade passes (only when its low time bits are zero), then the expiry scan.
// Each pass steps one timer at a time through the per-timer memories and the shared adder.
// Results: one cycle per item on expired_valid_o, possibly back to back; no stalling.
// Reset (asynchronous): time zero, all timers inactive, no clearing pass.
module hierarchical_timing_wheel_unit
  import htw_pkg::*;
#(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF,
  parameter int NEAR_BITS   = NEAR_BITS_DEF,
  parameter int LEVEL_BITS  = LEVEL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [5:0]         timer_id_i,
  input  logic [31:0]        interval_i,
  input  logic signed [16:0] repeat_count_i,
  output logic               expired_valid_o,
  output logic [5:0]         expired_id_o,
  output logic               fired_o,
  output logic               last_o
);

  localparam int ID_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int BKT_W = ((NEAR_BITS > LEVEL_BITS + 2) ? NEAR_BITS : LEVEL_BITS + 2) + 1;
  localparam int SH0   = NEAR_BITS;
  localparam int SH1   = NEAR_BITS + LEVEL_BITS;
  localparam int SH2   = NEAR_BITS + 2 * LEVEL_BITS;
  localparam int SH3   = NEAR_BITS + 3 * LEVEL_BITS;
  localparam logic [BKT_W-1:0] BASE0 = BKT_W'(1 << NEAR_BITS);
  localparam logic [BKT_W-1:0] BASE1 = BKT_W'((1 << NEAR_BITS) + (1 << LEVEL_BITS));
  localparam logic [BKT_W-1:0] BASE2 = BKT_W'((1 << NEAR_BITS) + 2 * (1 << LEVEL_BITS));
  localparam logic [BKT_W-1:0] BASE3 = BKT_W'((1 << NEAR_BITS) + 3 * (1 << LEVEL_BITS));
  localparam logic [ID_W-1:0]  ID_LAST = ID_W'(TIMER_COUNT - 1);

  // per-timer stores
  logic [63:0]        trig_mem [TIMER_COUNT];
  logic [31:0]        ivl_mem  [TIMER_COUNT];
  logic signed [16:0] cnt_mem  [TIMER_COUNT];
  logic [BKT_W-1:0]   bkt_mem  [TIMER_COUNT];

  logic [63:0]        trig_rd_q;
  logic [31:0]        ivl_rd_q;
  logic signed [16:0] cnt_rd_q;
  logic [BKT_W-1:0]   bkt_rd_q;

  state_e             state_q, state_d;
  mode_e              mode_q;
  logic [TIMER_COUNT-1:0] act_q;
  logic [63:0]        cur_q, t_q, d_q;
  logic [31:0]        ivl_q;
  logic [ID_W-1:0]    addr_q;
  logic [1:0]         lvl_q;
  logic [BKT_W-1:0]   target_q;
  logic [NEAR_BITS-1:0] idx_q;
  logic               pend_q;
  logic [5:0]         pend_id_q;
  logic               pend_fired_q;
  logic               out_valid_q, out_fired_q, out_last_q;
  logic [5:0]         out_id_q;

  logic               accept, id_ok, match, pass_end, casc_stop;
  logic [LEVEL_BITS-1:0] li;
  logic [BKT_W-1:0]   lvl_base, file_bkt;
  logic [63:0]        add_a, add_b, add_sum;
  logic               add_sub;

  assign accept = start && (state_q == ST_IDLE);
  assign id_ok  = 32'(timer_id_i) < 32'(TIMER_COUNT);
  assign busy   = (state_q != ST_IDLE);
  assign match  = act_q[addr_q] && (bkt_rd_q == target_q);
  assign pass_end = (addr_q == ID_LAST);

  always_comb begin
    case (lvl_q)
      2'd0: begin li = cur_q[SH0 +: LEVEL_BITS]; lvl_base = BASE0; end
      2'd1: begin li = cur_q[SH1 +: LEVEL_BITS]; lvl_base = BASE1; end
      2'd2: begin li = cur_q[SH2 +: LEVEL_BITS]; lvl_base = BASE2; end
      default: begin li = cur_q[SH3 +: LEVEL_BITS]; lvl_base = BASE3; end
    endcase
  end
  assign casc_stop = (li != '0) || (lvl_q == 2'd3);

  // shared adder
  always_comb begin
    add_a   = cur_q;
    add_b   = 64'd1;
    add_sub = 1'b0;
    case (state_q)
      ST_ADD: begin
        if (mode_q == MODE_ARM) begin
          add_a = cur_q;
          add_b = {32'd0, ivl_q};
        end else begin
          add_a = trig_rd_q;
          add_b = {32'd0, ivl_rd_q};
        end
      end
      ST_SUB: begin
        add_a   = t_q;
        add_b   = ~cur_q;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end
  assign add_sum = add_a + add_b + {63'd0, add_sub};

  // bucket choice from distance and trigger
  always_comb begin
    if (d_q[63]) begin
      file_bkt = BKT_W'(cur_q[NEAR_BITS-1:0]);
    end else if (d_q[63:SH0] == '0) begin
      file_bkt = BKT_W'(t_q[NEAR_BITS-1:0]);
    end else if (d_q[63:SH1] == '0) begin
      file_bkt = BASE0 + BKT_W'(t_q[SH0 +: LEVEL_BITS]);
    end else if (d_q[63:SH2] == '0) begin
      file_bkt = BASE1 + BKT_W'(t_q[SH1 +: LEVEL_BITS]);
    end else if (d_q[63:SH3] == '0) begin
      file_bkt = BASE2 + BKT_W'(t_q[SH2 +: LEVEL_BITS]);
    end else begin
      file_bkt = BASE3 + BKT_W'(t_q[SH3 +: LEVEL_BITS]);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && func_i == FUNC_ARM && id_ok) begin
          state_d = ST_ADD;
        end else if (accept && func_i == FUNC_TICK) begin
          state_d = (cur_q[NEAR_BITS-1:0] == '0) ? ST_RD : ST_INC;
        end
      end
      ST_RD: state_d = ST_CHK;
      ST_CHK: begin
        if (match && mode_q == MODE_CASC) begin
          state_d = ST_SUB;
        end else if (match && cnt_rd_q != '0) begin
          state_d = ST_ADD;
        end else if (!pass_end) begin
          state_d = ST_RD;
        end else if (mode_q == MODE_EXP) begin
          state_d = ST_DONE;
        end else begin
          state_d = casc_stop ? ST_INC : ST_RD;
        end
      end
      ST_ADD: state_d = ST_SUB;
      ST_SUB: state_d = ST_FILE;
      ST_FILE: begin
        if (mode_q == MODE_ARM) begin
          state_d = ST_IDLE;
        end else if (!pass_end) begin
          state_d = ST_RD;
        end else if (mode_q == MODE_EXP) begin
          state_d = ST_DONE;
        end else begin
          state_d = casc_stop ? ST_INC : ST_RD;
        end
      end
      ST_INC: state_d = ST_RD;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    trig_rd_q <= trig_mem[addr_q];
    ivl_rd_q  <= ivl_mem[addr_q];
    cnt_rd_q  <= cnt_mem[addr_q];
    bkt_rd_q  <= bkt_mem[addr_q];
    if (accept && func_i == FUNC_ARM && id_ok) begin
      ivl_mem[ID_W'(timer_id_i)] <= interval_i;
      cnt_mem[ID_W'(timer_id_i)] <= repeat_count_i;
    end else if (state_q == ST_CHK && match && mode_q == MODE_EXP && !cnt_rd_q[16]
                 && cnt_rd_q != '0) begin
      cnt_mem[addr_q] <= cnt_rd_q - 17'sd1;
    end
    if (state_q == ST_ADD) begin
      trig_mem[addr_q] <= add_sum;
    end
    if (state_q == ST_FILE) begin
      bkt_mem[addr_q] <= file_bkt;
    end
  end

  // datapath without reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        ivl_q    <= interval_i;
        addr_q   <= ID_W'(timer_id_i);
        idx_q    <= cur_q[NEAR_BITS-1:0];
        lvl_q    <= 2'd0;
        target_q <= BASE0 + BKT_W'(cur_q[SH0 +: LEVEL_BITS]);
        if (func_i == FUNC_TICK) begin
          addr_q <= '0;
          mode_q <= MODE_CASC;
        end else begin
          mode_q <= MODE_ARM;
        end
      end
      ST_CHK: begin
        t_q <= trig_rd_q;
        if (state_d == ST_RD) begin
          addr_q <= pass_end ? '0 : addr_q + ID_W'(1);
          if (pass_end) begin
            lvl_q    <= lvl_q + 2'd1;
            target_q <= BKT_W'(lvl_base + BKT_W'(1 << LEVEL_BITS)) + BKT_W'(
                        (lvl_q == 2'd0) ? cur_q[SH1 +: LEVEL_BITS] :
                        (lvl_q == 2'd1) ? cur_q[SH2 +: LEVEL_BITS] :
                                          cur_q[SH3 +: LEVEL_BITS]);
          end
        end
        if (state_d == ST_INC) addr_q <= '0;
      end
      ST_ADD: t_q <= add_sum;
      ST_SUB: d_q <= add_sum;
      ST_FILE: begin
        if (state_d == ST_RD) begin
          addr_q <= pass_end ? '0 : addr_q + ID_W'(1);
          if (pass_end) begin
            lvl_q    <= lvl_q + 2'd1;
            target_q <= BKT_W'(lvl_base + BKT_W'(1 << LEVEL_BITS)) + BKT_W'(
                        (lvl_q == 2'd0) ? cur_q[SH1 +: LEVEL_BITS] :
                        (lvl_q == 2'd1) ? cur_q[SH2 +: LEVEL_BITS] :
                                          cur_q[SH3 +: LEVEL_BITS]);
          end
        end
        if (state_d == ST_INC) addr_q <= '0;
      end
      ST_INC: begin
        mode_q   <= MODE_EXP;
        addr_q   <= '0;
        target_q <= BKT_W'(idx_q);
      end
      default: ;
    endcase
  end

  // control state, time, active bits and result items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q        <= '0;
      act_q        <= '0;
      pend_q       <= 1'b0;
      pend_id_q    <= '0;
      pend_fired_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_id_q     <= '0;
      out_fired_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      if (accept && func_i == FUNC_KILL && id_ok) begin
        act_q[ID_W'(timer_id_i)] <= 1'b0;
      end
      if (state_q == ST_INC) begin
        cur_q <= add_sum;
      end
      if (state_q == ST_FILE) begin
        act_q[addr_q] <= 1'b1;
      end
      if (state_q == ST_CHK && match && mode_q == MODE_EXP) begin
        act_q[addr_q] <= 1'b0;
        pend_q        <= 1'b1;
        pend_id_q     <= 6'(addr_q);
        pend_fired_q  <= (cnt_rd_q != '0);
        if (pend_q) begin
          out_valid_q <= 1'b1;
          out_id_q    <= pend_id_q;
          out_fired_q <= pend_fired_q;
          out_last_q  <= 1'b0;
        end
      end
      if (state_q == ST_DONE && pend_q) begin
        pend_q      <= 1'b0;
        out_valid_q <= 1'b1;
        out_id_q    <= pend_id_q;
        out_fired_q <= pend_fired_q;
        out_last_q  <= 1'b1;
      end
    end
  end

  assign expired_valid_o = out_valid_q;
  assign expired_id_o    = out_id_q;
  assign fired_o         = out_fired_q;
  assign last_o          = out_last_q;

endmodule

@@ hdl/htw_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the timing wheel unit, bound to the top level.
// No dependencies beyond the top level's ports.
module htw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic expired_valid_o,
  input logic last_o
);

  a_more_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expired_valid_o && !last_o |-> busy)
    else $error("non-final item shown while idle");

  a_last_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expired_valid_o && last_o |-> !busy)
    else $error("final item shown while still working");

  a_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !expired_valid_o)
    else $error("item from an idle unit");

endmodule

bind hierarchical_timing_wheel_unit htw_checker u_htw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .expired_valid_o (expired_valid_o),
  .last_o          (last_o)
);

@@ verif/htw_checker.sv @@
`timescale 1ns / 1ps
// Expiry checker for the hierarchical timing wheel unit.
// Mirrors the wheel from accepted items and compares every expiry strobe. Depends on htw_pkg.
module htw_scoreboard
  import htw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         func_i,
  input  logic [5:0]         timer_id_i,
  input  logic [31:0]        interval_i,
  input  logic signed [16:0] repeat_count_i,
  input  logic               expired_valid_i,
  input  logic [5:0]         expired_id_i,
  input  logic               fired_i,
  input  logic               last_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  localparam int NTIM = TIMER_COUNT_DEF;
  localparam int NB   = NEAR_BITS_DEF;
  localparam int LB   = LEVEL_BITS_DEF;

  typedef struct packed {
    logic [5:0] id;
    logic       fired;
    logic       last;
  } expiry_t;

  logic [63:0] now_ms;
  logic [63:0] trig_ms [NTIM];
  logic [31:0] period_ms [NTIM];
  int          shots_left [NTIM];
  bit          armed [NTIM];
  int unsigned bucket [NTIM];
  expiry_t     expiry_q [$];

  assign pending_o = expiry_q.size();

  function automatic void place_timer(int id);
    logic [63:0] d;
    int unsigned b;
    int sh;
    d = trig_ms[id] - now_ms;
    if (d[63]) begin
      b = 32'(now_ms[NB-1:0]);
    end else if (d < (64'd1 << NB)) begin
      b = 32'(trig_ms[id][NB-1:0]);
    end else begin
      b = 0;
      for (int k = 0; k < 4; k++) begin
        sh = NB + k * LB;
        if (k == 3 || d < (64'd1 << (sh + LB))) begin
          b = 32'((1 << NB) + k * (1 << LB) + ((trig_ms[id] >> sh) & ((1 << LB) - 1)));
          break;
        end
      end
    end
    bucket[id] = b;
    armed[id] = 1'b1;
  endfunction

  function automatic void advance_ms();
    int unsigned idx;
    int unsigned li;
    int unsigned b;
    bit fire;
    expiry_t e;
    int n;
    idx = 32'(now_ms[NB-1:0]);
    n = 0;
    if (idx == 0) begin
      for (int k = 0; k < 4; k++) begin
        li = 32'((now_ms >> (NB + k * LB)) & ((1 << LB) - 1));
        b = (1 << NB) + k * (1 << LB) + li;
        for (int i = 0; i < NTIM; i++)
          if (armed[i] && bucket[i] == b) place_timer(i);
        if (li != 0) break;
      end
    end
    now_ms = now_ms + 64'd1;
    for (int i = 0; i < NTIM; i++) begin
      if (!armed[i] || bucket[i] != idx) continue;
      armed[i] = 1'b0;
      if (shots_left[i] < 0) begin
        fire = 1'b1;
      end else if (shots_left[i] > 0) begin
        shots_left[i]--;
        fire = 1'b1;
      end else begin
        fire = 1'b0;
      end
      if (fire) begin
        trig_ms[i] = trig_ms[i] + {32'd0, period_ms[i]};
        place_timer(i);
      end
      e.id = i[5:0];
      e.fired = fire;
      e.last = 1'b0;
      expiry_q.insert(expiry_q.size(), e);
      n++;
    end
    if (n > 0) expiry_q[expiry_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_ms = '0;
      for (int i = 0; i < NTIM; i++) armed[i] = 1'b0;
      expiry_q.delete();
      fail_count_o <= 0;
    end else begin
      if (expired_valid_i) begin
        if (expiry_q.size() == 0) begin
          $error("expired_id expected none actual %0d", expired_id_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          expiry_t e;
          int unsigned errs;
          e = expiry_q.pop_front();
          errs = 0;
          if (expired_id_i !== e.id) begin
            $error("expired_id expected %0d actual %0d", e.id, expired_id_i);
            errs++;
          end
          if (fired_i !== e.fired) begin
            $error("fired expected %0d actual %0d", e.fired, fired_i);
            errs++;
          end
          if (last_i !== e.last) begin
            $error("last expected %0d actual %0d", e.last, last_i);
            errs++;
          end
          fail_count_o <= fail_count_o + errs;
        end
      end
      if (start_i && !busy_i) begin
        case (func_i)
          FUNC_ARM: begin
            period_ms[timer_id_i] = interval_i;
            shots_left[timer_id_i] = int'(repeat_count_i);
            trig_ms[timer_id_i] = now_ms + {32'd0, interval_i};
            place_timer(timer_id_i);
          end
          FUNC_KILL: armed[timer_id_i] = 1'b0;
          FUNC_TICK: advance_ms();
          default: ;
        endcase
      end
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the hierarchical timing wheel unit.
// Depends on htw_pkg, hierarchical_timing_wheel_unit and htw_scoreboard.
module testbench;
  import htw_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func_i = FUNC_TICK;
  logic [5:0]         timer_id_i = '0;
  logic [31:0]        interval_i = 32'd1;
  logic signed [16:0] repeat_count_i = '0;
  logic               expired_valid_o;
  logic [5:0]         expired_id_o;
  logic               fired_o;
  logic               last_o;
  int unsigned        pending;
  int unsigned        fail_count;

  always #5 clk_i = ~clk_i;

  hierarchical_timing_wheel_unit dut (.*);

  htw_scoreboard chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .func_i, .timer_id_i,
    .interval_i, .repeat_count_i, .expired_valid_i(expired_valid_o),
    .expired_id_i(expired_id_o), .fired_i(fired_o), .last_i(last_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  task automatic issue_item(logic [1:0] f, logic [5:0] id, logic [31:0] ivl,
                            logic signed [16:0] rc);
    int gap;
    func_i <= f;
    timer_id_i <= id;
    interval_i <= ivl;
    repeat_count_i <= rc;
    start <= 1'b1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_item();
    logic [1:0] f;
    logic [31:0] ivl;
    logic signed [16:0] rc;
    int r;
    r = $urandom_range(0, 99);
    f = (r < 78) ? FUNC_TICK : (r < 93) ? FUNC_ARM : (r < 98) ? FUNC_KILL : 2'd3;
    case ($urandom_range(0, 9))
      0: ivl = $urandom();
      1, 2: ivl = $urandom_range(1, 700);
      default: ivl = $urandom_range(1, 40);
    endcase
    if (ivl == 0) ivl = 1;
    case ($urandom_range(0, 5))
      0: rc = -17'sd1;
      1: rc = 17'($urandom());
      default: rc = 17'($urandom_range(0, 3));
    endcase
    issue_item(f, 6'($urandom()), ivl, rc);
  endtask

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, repeat forms, re-arm, kill, unused code
    issue_item(FUNC_ARM, 6'd0, 32'd1, 17'sd0);
    issue_item(FUNC_ARM, 6'd63, 32'hFFFF_FFFF, -17'sd1);
    issue_item(FUNC_ARM, 6'd5, 32'd3, 17'sd65535);
    issue_item(FUNC_ARM, 6'd6, 32'd3, 17'sh1_0000);
    issue_item(FUNC_ARM, 6'd7, 32'd2, 17'sd2);
    issue_item(FUNC_ARM, 6'd8, 32'd300, 17'sd1);
    issue_item(FUNC_KILL, 6'd40, 32'd1, 17'sd0);
    issue_item(2'd3, 6'd1, 32'd1, 17'sd0);
    repeat (3) issue_item(FUNC_TICK, 6'd0, 32'd1, 17'sd0);
    issue_item(FUNC_ARM, 6'd7, 32'd4, 17'sd1);
    issue_item(FUNC_KILL, 6'd5, 32'd1, 17'sd0);
    issue_item(FUNC_KILL, 6'd63, 32'd1, 17'sd0);
    repeat (8) issue_item(FUNC_TICK, 6'h2A, 32'h5555_AAAA, 17'sd0);
    repeat (280) random_item();
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
